[hdl/spq_pkg.sv]
// spq_pkg: types and codes shared by the priority queue controller, datapath and top level
// no dependencies

package spq_pkg;

   localparam int DATA_BITS     = 32;
   localparam int PRIORITY_BITS = 16;
   localparam int OCC_BITS      = 7;
   localparam int STATUS_BITS   = 2;

   // opcodes
   localparam logic OPCODE_INSERT = 1'b0;
   localparam logic OPCODE_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW  = 2'd2;

   // request beat
   typedef struct packed {
      logic                            opcode;
      logic signed [DATA_BITS-1:0]     item_data;
      logic        [PRIORITY_BITS-1:0] item_priority;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [DATA_BITS-1:0] removed_data;
      logic [STATUS_BITS-1:0]      status;
      logic signed [DATA_BITS-1:0] head_data;
      logic                        head_valid;
      logic [OCC_BITS-1:0]         occupancy;
   } rsp_type;

   // one stored entry
   typedef struct packed {
      logic [PRIORITY_BITS-1:0]    key;
      logic signed [DATA_BITS-1:0] data;
   } entry_type;

   // controller to datapath commands
   typedef struct packed {
      logic                   load;
      logic [STATUS_BITS-1:0] status;
      logic                   rd_prev;
      logic                   shift;
      logic                   place;
      logic                   pop;
      logic                   head_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;
      logic full;
      logic last_entry;
      logic last_hole;
      logic key_greater;
   } stat_type;

endpackage

[hdl/stable_min_priority_queue.sv]
// stable_min_priority_queue: bounded stable min priority queue, top level
// depends on spq_pkg, spq_ctrl, spq_datapath
//
//   channel   handshake            payload
//   request   start, busy          req_item (opcode, item_data, item_priority)
//   result    rsp_strobe           rsp_item (removed_data, status, head_data, head_valid, occupancy)
//
// a request beat is taken when start is high and busy is low; its result beat
// shows on rsp_item for the single cycle rsp_strobe is high, and busy drops after it
// insert: scans down from the tail with one memory read per visited entry and one write per
// entry shifted up, then one write places the new entry; remove pops the head and refetches
// the new head unless the queue becomes empty; failed beats go straight to the result beat
// synchronous reset empties the queue, no memory clearing; the receiver never stalls

module stable_min_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_item,
   output logic             rsp_strobe,
   output spq_pkg::rsp_type rsp_item
);

   spq_pkg::cmd_type  cmd;
   spq_pkg::stat_type stat;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .opcode     (req_item.opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   spq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

endmodule

[hdl/spq_datapath.sv]
// spq_datapath: entry memory kept as a sorted ring, pointers, count and result registers
// depends on spq_pkg

module spq_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  spq_pkg::req_type  req_item,
   input  spq_pkg::cmd_type  cmd,
   output spq_pkg::stat_type stat,
   output spq_pkg::rsp_type  rsp_item
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);

   // entry memory
   spq_pkg::entry_type entry_mem [CAPACITY];
   spq_pkg::entry_type rd_entry_ff;
   logic [PTR_W-1:0]   rd_addr;
   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   spq_pkg::entry_type wr_entry;

   // pointers and count
   logic [PTR_W-1:0] head_ptr_ff, head_ptr_in;
   logic [PTR_W-1:0] tail_ptr_ff, tail_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] hole_ptr_ff, hole_ptr_in;
   logic [CNT_W-1:0] hole_idx_ff, hole_idx_in;

   // latched request and result registers
   spq_pkg::req_type               req_ff, req_in;
   logic signed [spq_pkg::DATA_BITS-1:0] head_data_ff, head_data_in;
   logic signed [spq_pkg::DATA_BITS-1:0] removed_ff, removed_in;
   logic [spq_pkg::STATUS_BITS-1:0]      status_ff, status_in;

   spq_pkg::entry_type new_entry;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_PTR : p - 1'b1;
   endfunction

   assign new_entry.key  = req_ff.item_priority;
   assign new_entry.data = req_ff.item_data;

   // memory port control
   always_comb begin
      rd_addr  = cmd.pop ? ptr_next(head_ptr_ff) : ptr_prev(hole_ptr_ff);
      wr_en    = cmd.shift | cmd.place;
      wr_addr  = hole_ptr_ff;
      wr_entry = cmd.shift ? rd_entry_ff : new_entry;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_entry;
      end
      if (cmd.rd_prev | cmd.pop) begin
         rd_entry_ff <= entry_mem[rd_addr];
      end
   end

   // next state of pointers and registers
   always_comb begin
      head_ptr_in  = head_ptr_ff;
      tail_ptr_in  = tail_ptr_ff;
      count_in     = count_ff;
      hole_ptr_in  = hole_ptr_ff;
      hole_idx_in  = hole_idx_ff;
      req_in       = req_ff;
      head_data_in = head_data_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      if (cmd.load) begin
         req_in      = req_item;
         hole_ptr_in = tail_ptr_ff;
         hole_idx_in = count_ff;
         removed_in  = '0;
         status_in   = cmd.status;
      end
      if (cmd.shift) begin
         hole_ptr_in = ptr_prev(hole_ptr_ff);
         hole_idx_in = hole_idx_ff - 1'b1;
      end
      if (cmd.place) begin
         tail_ptr_in = ptr_next(tail_ptr_ff);
         count_in    = count_ff + 1'b1;
         if (hole_idx_ff == '0) begin
            head_data_in = req_ff.item_data;
         end
      end
      if (cmd.pop) begin
         removed_in  = head_data_ff;
         head_ptr_in = ptr_next(head_ptr_ff);
         count_in    = count_ff - 1'b1;
      end
      if (cmd.head_load) begin
         head_data_in = rd_entry_ff.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff <= '0;
         tail_ptr_ff <= '0;
         count_ff    <= '0;
      end else begin
         head_ptr_ff <= head_ptr_in;
         tail_ptr_ff <= tail_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hole_ptr_ff  <= hole_ptr_in;
      hole_idx_ff  <= hole_idx_in;
      req_ff       <= req_in;
      head_data_ff <= head_data_in;
      removed_ff   <= removed_in;
      status_ff    <= status_in;
   end

   // status to controller
   always_comb begin
      stat.empty       = (count_ff == '0);
      stat.full        = (count_ff == CNT_W'(CAPACITY));
      stat.last_entry  = (count_ff == CNT_W'(1));
      stat.last_hole   = (hole_idx_ff == CNT_W'(1));
      stat.key_greater = (rd_entry_ff.key > req_ff.item_priority);
   end

   // result beat
   always_comb begin
      rsp_item.removed_data = removed_ff;
      rsp_item.status       = status_ff;
      rsp_item.head_valid   = (count_ff != '0);
      rsp_item.head_data    = (count_ff != '0) ? head_data_ff : '0;
      rsp_item.occupancy    = spq_pkg::OCC_BITS'(count_ff);
   end

endmodule

[hdl/spq_ctrl.sv]
// spq_ctrl: sequencer for insert (backward shift scan) and remove (pop, head refetch)
// depends on spq_pkg

module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              opcode,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_strobe
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_READ  = 7'b0000010,
      S_CMP   = 7'b0000100,
      S_PLACE = 7'b0001000,
      S_POP   = 7'b0010000,
      S_HEAD  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.status    = spq_pkg::STATUS_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (opcode == spq_pkg::OPCODE_INSERT) begin
                  if (stat.full) begin
                     cmd.status = spq_pkg::STATUS_OVERFLOW;
                     state_in   = S_DONE;
                  end else if (stat.empty) begin
                     state_in = S_PLACE;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  if (stat.empty) begin
                     cmd.status = spq_pkg::STATUS_UNDERFLOW;
                     state_in   = S_DONE;
                  end else begin
                     state_in = S_POP;
                  end
               end
            end
         end
         // fetch the entry just below the hole
         S_READ: begin
            cmd.rd_prev = 1'b1;
            state_in    = S_CMP;
         end
         // move it up if its key is larger, else the hole is the slot
         S_CMP: begin
            if (stat.key_greater) begin
               cmd.shift = 1'b1;
               state_in  = stat.last_hole ? S_PLACE : S_READ;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_DONE;
         end
         // drop the head and fetch its successor
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = stat.last_entry ? S_DONE : S_HEAD;
         end
         S_HEAD: begin
            cmd.head_load = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking testbench for the stable min priority queue
// depends on spq_pkg and stable_min_priority_queue

module tb_top;

   localparam int QUEUE_DEPTH  = 64;
   localparam int ITEM_TARGET  = 1600;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int CLOCK_PERIOD = 10;
   localparam int DIRECTED_LEN = 20;

   // one row of the directed table; golden is used only where pinned is set
   typedef struct packed {
      spq_pkg::req_type beat;
      logic             pinned;
      spq_pkg::rsp_type golden;
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   spq_pkg::req_type req_item;
   logic             rsp_strobe;
   spq_pkg::rsp_type rsp_item;

   // scoreboard state
   spq_pkg::entry_type held_entries[$];
   spq_pkg::rsp_type   pending_results[$];
   logic               pinned_valid;
   spq_pkg::rsp_type   pinned_result;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned items_sent = 0;
   int unsigned quiet_left = 0;

   // directed beats: empty remove, extremes, equal keys, drain to empty
   directed_row_type directed_rows [DIRECTED_LEN] = '{
      '{'{spq_pkg::OPCODE_REMOVE, 32'h0000_0000, 16'h0000}, 1'b1,
        '{32'h0, spq_pkg::STATUS_UNDERFLOW, 32'h0, 1'b0, 7'd0}},
      '{'{spq_pkg::OPCODE_INSERT, 32'h7FFF_FFFF, 16'hFFFF}, 1'b1,
        '{32'h0, spq_pkg::STATUS_OK, 32'h7FFF_FFFF, 1'b1, 7'd1}},
      '{'{spq_pkg::OPCODE_INSERT, 32'h8000_0000, 16'h0000}, 1'b1,
        '{32'h0, spq_pkg::STATUS_OK, 32'h8000_0000, 1'b1, 7'd2}},
      '{'{spq_pkg::OPCODE_INSERT, 32'h0000_0001, 16'h0000}, 1'b1,
        '{32'h0, spq_pkg::STATUS_OK, 32'h8000_0000, 1'b1, 7'd3}},
      '{'{spq_pkg::OPCODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
        '{32'h0, spq_pkg::STATUS_OK, 32'h8000_0000, 1'b1, 7'd4}},
      '{'{spq_pkg::OPCODE_INSERT, 32'h0000_0000, 16'h8000}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_INSERT, 32'h5555_5555, 16'h5555}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_INSERT, 32'hAAAA_AAAA, 16'hAAAA}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_REMOVE, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
        '{32'h8000_0000, spq_pkg::STATUS_OK, 32'h0000_0001, 1'b1, 7'd6}},
      '{'{spq_pkg::OPCODE_REMOVE, 32'h0000_0000, 16'h0000}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_INSERT, 32'h1234_5678, 16'h0001}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_INSERT, 32'h0BAD_F00D, 16'h0001}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_REMOVE, 32'h0000_0000, 16'h0000}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_REMOVE, 32'h0000_0000, 16'h0000}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_REMOVE, 32'h0000_0000, 16'h0000}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_REMOVE, 32'h0000_0000, 16'h0000}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_REMOVE, 32'h0000_0000, 16'h0000}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_REMOVE, 32'h0000_0000, 16'h0000}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_REMOVE, 32'h0000_0000, 16'h0000}, 1'b0, '0},
      '{'{spq_pkg::OPCODE_REMOVE, 32'h0000_0000, 16'h0000}, 1'b1,
        '{32'h0, spq_pkg::STATUS_UNDERFLOW, 32'h0, 1'b0, 7'd0}}
   };

   stable_min_priority_queue #(
      .CAPACITY (QUEUE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // sorted-list model: apply one beat, return the result it should produce
   function automatic spq_pkg::rsp_type predict_queue_op(input spq_pkg::req_type beat);
      spq_pkg::rsp_type   outcome;
      spq_pkg::entry_type fresh;
      int                 pos;
      outcome = '0;
      if (beat.opcode == spq_pkg::OPCODE_INSERT) begin
         if (held_entries.size() >= QUEUE_DEPTH) begin
            outcome.status = spq_pkg::STATUS_OVERFLOW;
         end else begin
            // stable: new entry goes after every held key that is <= its own
            pos = 0;
            while (pos < held_entries.size() && held_entries[pos].key <= beat.item_priority)
               pos++;
            fresh.key  = beat.item_priority;
            fresh.data = beat.item_data;
            held_entries.insert(pos, fresh);
            outcome.status = spq_pkg::STATUS_OK;
         end
      end else begin
         if (held_entries.size() == 0) begin
            outcome.status = spq_pkg::STATUS_UNDERFLOW;
         end else begin
            outcome.removed_data = held_entries[0].data;
            held_entries.delete(0);
            outcome.status = spq_pkg::STATUS_OK;
         end
      end
      if (held_entries.size() > 0) begin
         outcome.head_data  = held_entries[0].data;
         outcome.head_valid = 1'b1;
      end
      outcome.occupancy = spq_pkg::OCC_BITS'(held_entries.size());
      return outcome;
   endfunction

   // compare one result beat against the oldest pending one
   function automatic void check_result_beat(input spq_pkg::rsp_type seen);
      spq_pkg::rsp_type wanted;
      if (pending_results.size() == 0) begin
         $display("%0t: result beat with nothing pending, got %h", $time, seen);
         mismatch_count++;
      end else begin
         wanted = pending_results.pop_front();
         if (seen.removed_data !== wanted.removed_data) begin
            $display("%0t: removed_data expected %h, got %h", $time,
                     wanted.removed_data, seen.removed_data);
            mismatch_count++;
         end
         if (seen.status !== wanted.status) begin
            $display("%0t: status expected %0d, got %0d", $time, wanted.status, seen.status);
            mismatch_count++;
         end
         if (seen.head_data !== wanted.head_data) begin
            $display("%0t: head_data expected %h, got %h", $time,
                     wanted.head_data, seen.head_data);
            mismatch_count++;
         end
         if (seen.head_valid !== wanted.head_valid) begin
            $display("%0t: head_valid expected %0d, got %0d", $time,
                     wanted.head_valid, seen.head_valid);
            mismatch_count++;
         end
         if (seen.occupancy !== wanted.occupancy) begin
            $display("%0t: occupancy expected %0d, got %0d", $time,
                     wanted.occupancy, seen.occupancy);
            mismatch_count++;
         end
      end
   endfunction

   // random beat; keys lean toward a narrow range so equal keys are common
   function automatic spq_pkg::req_type random_beat(input logic op);
      spq_pkg::req_type beat;
      beat.opcode = op;
      case ($urandom_range(0, 9))
         0:       beat.item_data = 32'h8000_0000;
         1:       beat.item_data = 32'h7FFF_FFFF;
         default: beat.item_data = $urandom;
      endcase
      case ($urandom_range(0, 9)) inside
         0:       beat.item_priority = 16'h0000;
         1:       beat.item_priority = 16'hFFFF;
         [2:5]:   beat.item_priority = spq_pkg::PRIORITY_BITS'($urandom_range(0, 7));
         [6:7]:   beat.item_priority = spq_pkg::PRIORITY_BITS'($urandom_range(0, 255));
         default: beat.item_priority = spq_pkg::PRIORITY_BITS'($urandom_range(0, 16'hFFFF));
      endcase
      return beat;
   endfunction

   // drive one request beat after a random gap and wait for it to be taken
   task automatic send_item(input spq_pkg::req_type beat, input logic pin = 1'b0,
                            input spq_pkg::rsp_type pinned = '0);
      int unsigned gap;
      if (quiet_left > 0) begin
         gap = 0;
         quiet_left--;
      end else begin
         gap = $urandom_range(0, 14);
         if ($urandom_range(0, 39) == 0)
            quiet_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item      = beat;
      pinned_valid  = pin;
      pinned_result = pinned;
      start         = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      items_sent++;
   endtask

   // monitor: check result beats, predict on every accepted request beat
   always @(posedge clock) begin : monitor
      logic             taken;
      spq_pkg::rsp_type predicted;
      if (!reset) begin
         taken = start && !busy;
         if (rsp_strobe)
            check_result_beat(rsp_item);
         if (taken) begin
            predicted = predict_queue_op(req_item);
            pending_results.push_back(pinned_valid ? pinned_result : predicted);
         end
         idle_cycles = taken ? 0 : idle_cycles + 1;
      end
   end

   // watchdog on cycles with no request beat taken
   initial begin
      do @(negedge clock); while (idle_cycles < STALL_LIMIT);
      $display("%0t: no request beat taken for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // stimulus
   initial begin
      int unsigned episode;
      int unsigned span;
      reset         = 1'b1;
      start         = 1'b0;
      req_item      = '0;
      pinned_valid  = 1'b0;
      pinned_result = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].golden);

      while (items_sent < ITEM_TARGET) begin
         episode = $urandom_range(0, 9);
         if (episode < 2) begin
            // fill to capacity, then a few inserts past it
            span = $urandom_range(1, 4);
            while (held_entries.size() < QUEUE_DEPTH)
               send_item(random_beat(spq_pkg::OPCODE_INSERT));
            repeat (span) send_item(random_beat(spq_pkg::OPCODE_INSERT));
         end else if (episode < 4) begin
            // drain to empty, then a few removes past it
            span = $urandom_range(1, 3);
            while (held_entries.size() > 0)
               send_item(random_beat(spq_pkg::OPCODE_REMOVE));
            repeat (span) send_item(random_beat(spq_pkg::OPCODE_REMOVE));
         end else begin
            // mixed traffic leaning toward inserts
            span = $urandom_range(10, 60);
            repeat (span)
               send_item(random_beat(($urandom_range(0, 9) < 6) ? spq_pkg::OPCODE_INSERT
                                                                  : spq_pkg::OPCODE_REMOVE));
         end
      end
      start = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

[files.f]
hdl/spq_pkg.sv
hdl/spq_datapath.sv
hdl/spq_ctrl.sv
hdl/stable_min_priority_queue.sv
tb/sv/tb_top.sv
